// ===== design/delta_rule_state_update_macros.svh =====
// ----------------------------------------------------------------------------
// delta_rule_state_update_macros
// Assertion helpers shared by the block's top level.
// ----------------------------------------------------------------------------
`ifndef DELTA_RULE_STATE_UPDATE_MACROS_SVH
`define DELTA_RULE_STATE_UPDATE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DRSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define DRSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/drsu_pkg.sv =====
// ----------------------------------------------------------------------------
// drsu_pkg
// Shared widths, defaults, control structs and the round/saturate helper.
// ----------------------------------------------------------------------------
package drsu_pkg;

    localparam int DEF_ROW_LEN  = 64;
    localparam int DEF_HEAD_CNT = 4;

    localparam int ACT_W   = 2;
    localparam int HEAD_W  = 2;
    localparam int IDX_W   = 6;
    localparam int VEC_W   = 16;
    localparam int ST_W    = 32;
    localparam int ACC_W   = 56;

    localparam logic [ACT_W-1:0] ACT_LOAD_VEC = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_ST  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UPDATE   = 2'd2;

    // Decoded kind of an accepted word, after range checks.
    typedef struct packed {
        logic vec_ok;
        logic st_ok;
        logic upd_ok;
    } t_item_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             ld_item;
        logic             issue;
        logic             is_dot;
        logic [IDX_W-1:0] col;
        logic             clear_acc;
        logic             latch_dot;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;
        logic adv;
    } t_dp_status;

    // Round a value with 28 fraction bits to 16, then saturate to 32 bits.
    function automatic logic signed [ST_W-1:0] round_sat(input logic signed [ACC_W-1:0] t);
        logic signed [ACC_W-1:0] q;
        begin
            q = (t + ACC_W'(2048)) >>> 12;
            if (q > $signed({{(ACC_W-ST_W+1){1'b0}}, {(ST_W-1){1'b1}}})) begin
                round_sat = {1'b0, {(ST_W-1){1'b1}}};
            end else if (q < $signed({{(ACC_W-ST_W+1){1'b1}}, {(ST_W-1){1'b0}}})) begin
                round_sat = {1'b1, {(ST_W-1){1'b0}}};
            end else begin
                round_sat = q[ST_W-1:0];
            end
        end
    endfunction

endpackage

// ===== design/delta_rule_state_update.sv =====
// ----------------------------------------------------------------------------
// delta_rule_state_update
// Per-head state matrix with a row-wise delta-rule update and streamed result.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                 Contents
//  s_axis    in   s_axis_tvalid/tready      action (tuser), item fields (tdata)
//  m_axis    out  m_axis_tvalid/tready      entry position and value, tlast
//
// A load word is written as it is accepted. An update makes ROW_LEN reads
// of the single state read port for the dot product, a pipeline drain,
// then ROW_LEN reads that feed the multiply pipeline, one result per cycle
// unless the output stalls. A stalled output freezes the whole pipeline.
// Memories need no clearing after reset; entries are undefined until written.
module delta_rule_state_update import drsu_pkg::*; #(
    parameter int ROW_LEN  = DEF_ROW_LEN,
    parameter int HEAD_CNT = DEF_HEAD_CNT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // head[1:0], row[7:2], col[13:8], decay[29:14], key[45:30], probe[61:46],
    // inject[77:62], value[93:78], state_in_val[125:94], zero[127:126]
    input  logic [127:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_head[1:0], out_row[7:2], out_col[13:8], state_out[45:14], zero[47:46]
    output logic [47:0]  m_axis_tdata,
    output logic         m_axis_tlast
);

    `include "delta_rule_state_update_macros.svh"

    logic              accept;
    logic [HEAD_W-1:0] f_head;
    logic [IDX_W-1:0]  f_row, f_col;
    logic              head_ok, row_ok, col_ok;
    t_item_kind        kind;
    t_dp_cmd           cmd;
    t_dp_status        status;
    logic [HEAD_W-1:0] o_head;
    logic [IDX_W-1:0]  o_row, o_col;
    logic [ST_W-1:0]   o_state;

    assign f_head  = s_axis_tdata[1:0];
    assign f_row   = s_axis_tdata[7:2];
    assign f_col   = s_axis_tdata[13:8];
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign head_ok = (32'(f_head) < HEAD_CNT);
    assign row_ok  = (32'(f_row) < ROW_LEN);
    assign col_ok  = (32'(f_col) < ROW_LEN);

    // Kind of the word with its range checks.
    assign kind.vec_ok = head_ok && col_ok && (s_axis_tuser == ACT_LOAD_VEC);
    assign kind.st_ok  = head_ok && row_ok && col_ok && (s_axis_tuser == ACT_LOAD_ST);
    assign kind.upd_ok = head_ok && row_ok && (s_axis_tuser == ACT_UPDATE);

    drsu_ctrl #(.ROW_LEN(ROW_LEN)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_kind   (kind),
        .i_status (status),
        .o_ready  (s_axis_tready),
        .o_cmd    (cmd)
    );

    drsu_datapath #(.ROW_LEN(ROW_LEN), .HEAD_CNT(HEAD_CNT)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_kind      (kind),
        .i_head      (f_head),
        .i_row       (f_row),
        .i_col       (f_col),
        .i_decay     (s_axis_tdata[29:14]),
        .i_key       (s_axis_tdata[45:30]),
        .i_probe     (s_axis_tdata[61:46]),
        .i_inject    (s_axis_tdata[77:62]),
        .i_value     (s_axis_tdata[93:78]),
        .i_state     (s_axis_tdata[125:94]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_head  (o_head),
        .o_out_row   (o_row),
        .o_out_col   (o_col),
        .o_out_state (o_state),
        .o_out_last  (m_axis_tlast),
        .o_status    (status)
    );

    assign m_axis_tdata = {2'b00, o_state, o_col, o_row, o_head};

    // An accepted update closes the input until its row is done.
    `DRSU_ASSERT_NEXT(a_upd_blocks, i_clk, i_rst_n, accept && kind.upd_ok, !s_axis_tready)
    // Words are only taken with the pipeline empty.
    `DRSU_ASSERT_NOW(a_ready_empty, i_clk, i_rst_n, s_axis_tready, !status.busy)
    // Nothing is left in flight behind the last entry of a row.
    `DRSU_ASSERT_NOW(a_last_drained, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, !status.busy)

endmodule

// ===== design/drsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// drsu_ctrl
// Sequencer: takes words, runs the dot pass and the update pass over a row.
// ----------------------------------------------------------------------------
module drsu_ctrl import drsu_pkg::*; #(
    parameter int ROW_LEN = DEF_ROW_LEN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_item_kind i_kind,
    input  t_dp_status i_status,
    output logic       o_ready,
    output t_dp_cmd    o_cmd
);

    localparam int CNT_W = $clog2(ROW_LEN);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DOT_RUN  = 3'd1;
    localparam logic [2:0] S_DOT_WAIT = 3'd2;
    localparam logic [2:0] S_DOT_FIN  = 3'd3;
    localparam logic [2:0] S_UPD_RUN  = 3'd4;
    localparam logic [2:0] S_UPD_WAIT = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             run;
    logic             at_end;

    assign run    = (r_state == S_DOT_RUN) || (r_state == S_UPD_RUN);
    assign at_end = (r_cnt == CNT_W'(ROW_LEN - 1));

    // Next state and column counter.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_accept && i_kind.upd_ok) begin
                    n_state = S_DOT_RUN;
                end
            end
            S_DOT_RUN, S_UPD_RUN: begin
                if (i_status.adv) begin
                    n_cnt = r_cnt + CNT_W'(1);
                    if (at_end) begin
                        n_cnt   = '0;
                        n_state = (r_state == S_DOT_RUN) ? S_DOT_WAIT : S_UPD_WAIT;
                    end
                end
            end
            S_DOT_WAIT: begin
                if (!i_status.busy) begin
                    n_state = S_DOT_FIN;
                end
            end
            S_DOT_FIN: n_state = S_UPD_RUN;
            S_UPD_WAIT: begin
                if (!i_status.busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Commands to the datapath.
    assign o_ready         = (r_state == S_IDLE);
    assign o_cmd.ld_item   = i_accept;
    assign o_cmd.issue     = run;
    assign o_cmd.is_dot    = (r_state == S_DOT_RUN);
    assign o_cmd.col       = IDX_W'(r_cnt);
    assign o_cmd.clear_acc = (r_state == S_IDLE);
    assign o_cmd.latch_dot = (r_state == S_DOT_FIN);

endmodule

// ===== design/drsu_datapath.sv =====
// ----------------------------------------------------------------------------
// drsu_datapath
// Memories, multiply pipeline, dot accumulator and output register.
// ----------------------------------------------------------------------------
module drsu_datapath import drsu_pkg::*; #(
    parameter int ROW_LEN  = DEF_ROW_LEN,
    parameter int HEAD_CNT = DEF_HEAD_CNT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  t_item_kind              i_kind,
    input  logic [HEAD_W-1:0]       i_head,
    input  logic [IDX_W-1:0]        i_row,
    input  logic [IDX_W-1:0]        i_col,
    input  logic signed [VEC_W-1:0] i_decay,
    input  logic signed [VEC_W-1:0] i_key,
    input  logic signed [VEC_W-1:0] i_probe,
    input  logic signed [VEC_W-1:0] i_inject,
    input  logic signed [VEC_W-1:0] i_value,
    input  logic signed [ST_W-1:0]  i_state,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [HEAD_W-1:0]       o_out_head,
    output logic [IDX_W-1:0]        o_out_row,
    output logic [IDX_W-1:0]        o_out_col,
    output logic signed [ST_W-1:0]  o_out_state,
    output logic                    o_out_last,
    output t_dp_status              o_status
);

    localparam int S_DEPTH = HEAD_CNT * ROW_LEN * ROW_LEN;
    localparam int V_DEPTH = HEAD_CNT * ROW_LEN;
    localparam int SA_W    = $clog2(S_DEPTH);
    localparam int VA_W    = $clog2(V_DEPTH);

    logic [ST_W-1:0]    state_mem [S_DEPTH];
    logic [4*VEC_W-1:0] vec_mem   [V_DEPTH];

    logic [HEAD_W-1:0]       r_head;
    logic [IDX_W-1:0]        r_row;
    logic signed [VEC_W-1:0] r_value;
    logic signed [ST_W-1:0]  r_dot;
    logic signed [ACC_W-1:0] r_acc;

    logic                    adv;
    logic                    st_we;
    logic [SA_W-1:0]         st_waddr;
    logic [ST_W-1:0]         st_wdata;
    logic [SA_W-1:0]         st_raddr;
    logic [VA_W-1:0]         vec_raddr;

    // Read stage.
    logic                    r_vb, r_db_dot;
    logic [IDX_W-1:0]        r_cb;
    logic signed [ST_W-1:0]  r_s;
    logic [4*VEC_W-1:0]      r_vw;

    // Product stage.
    logic                    r_vc, r_dc_dot;
    logic [IDX_W-1:0]        r_cc;
    logic signed [ST_W+VEC_W-1:0]   r_p_sd, r_p_di;
    logic signed [2*VEC_W-1:0]      r_p_kv;

    // Sum stage.
    logic                    r_vd, r_dd_dot;
    logic [IDX_W-1:0]        r_cd;
    logic signed [ACC_W-1:0] r_sum;

    // Output register.
    logic                    r_vo;
    logic [HEAD_W-1:0]       r_ho;
    logic [IDX_W-1:0]        r_ro;
    logic [IDX_W-1:0]        r_co;
    logic signed [ST_W-1:0]  r_so;
    logic signed [ST_W-1:0]  res;

    logic signed [VEC_W-1:0] m_decay, m_key, m_probe, m_inject;

    assign adv = !r_vo || i_out_ready;
    assign res = round_sat(r_sum);

    assign st_raddr  = SA_W'((32'(r_head) * ROW_LEN + 32'(r_row)) * ROW_LEN
                       + 32'(i_cmd.col));
    assign vec_raddr = VA_W'(32'(r_head) * ROW_LEN + 32'(i_cmd.col));

    // One state write port: loads in idle, write-back when a result is registered.
    always_comb begin
        st_we    = 1'b0;
        st_waddr = SA_W'((32'(i_head) * ROW_LEN + 32'(i_row)) * ROW_LEN + 32'(i_col));
        st_wdata = i_state;
        if (i_cmd.ld_item && i_kind.st_ok) begin
            st_we = 1'b1;
        end else if (adv && r_vd && !r_dd_dot) begin
            st_we    = 1'b1;
            st_waddr = SA_W'((32'(r_head) * ROW_LEN + 32'(r_row)) * ROW_LEN
                       + 32'(r_cd));
            st_wdata = res;
        end
    end

    // State and vector memories.
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            state_mem[st_waddr] <= st_wdata;
        end
        if (i_cmd.ld_item && i_kind.vec_ok) begin
            vec_mem[VA_W'(32'(i_head) * ROW_LEN + 32'(i_col))] <=
                {i_inject, i_probe, i_key, i_decay};
        end
        if (adv) begin
            r_s  <= state_mem[st_raddr];
            r_vw <= vec_mem[vec_raddr];
        end
    end

    // Item fields of the update in progress.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item && i_kind.upd_ok) begin
            r_head  <= i_head;
            r_row   <= i_row;
            r_value <= i_value;
        end
    end

    assign m_decay  = r_vw[VEC_W-1:0];
    assign m_key    = r_vw[2*VEC_W-1:VEC_W];
    assign m_probe  = r_vw[3*VEC_W-1:2*VEC_W];
    assign m_inject = r_vw[4*VEC_W-1:3*VEC_W];

    // Products, sum, rounding and output payload. The output word keeps its own
    // head and row so a new update taken behind it cannot change them.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cb     <= i_cmd.col;
            r_db_dot <= i_cmd.is_dot;
            r_p_sd   <= r_s * (r_db_dot ? m_probe : m_decay);
            r_p_kv   <= m_key * r_value;
            r_p_di   <= r_dot * m_inject;
            r_cc     <= r_cb;
            r_dc_dot <= r_db_dot;
            r_sum    <= ACC_W'(r_p_sd) + (ACC_W'(r_p_kv) <<< 4) + ACC_W'(r_p_di);
            r_cd     <= r_cc;
            r_dd_dot <= r_dc_dot;
            r_ho     <= r_head;
            r_ro     <= r_row;
            r_co     <= r_cd;
            r_so     <= res;
        end
        if (i_cmd.latch_dot) begin
            r_dot <= round_sat(r_acc);
        end
    end

    // Stage valids and dot accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb  <= 1'b0;
            r_vc  <= 1'b0;
            r_vd  <= 1'b0;
            r_vo  <= 1'b0;
            r_acc <= '0;
        end else begin
            if (adv) begin
                r_vb <= i_cmd.issue;
                r_vc <= r_vb;
                r_vd <= r_vc;
                r_vo <= r_vd && !r_dd_dot;
            end
            if (i_cmd.clear_acc) begin
                r_acc <= '0;
            end else if (adv && r_vc && r_dc_dot) begin
                r_acc <= r_acc + ACC_W'(r_p_sd);
            end
        end
    end

    assign o_out_valid = r_vo;
    assign o_out_head  = r_ho;
    assign o_out_row   = r_ro;
    assign o_out_col   = r_co;
    assign o_out_state = r_so;
    assign o_out_last  = (r_co == IDX_W'(ROW_LEN - 1));
    assign o_status.busy = r_vb || r_vc || r_vd;
    assign o_status.adv  = adv;

endmodule
